>>> hdl/rbe_pkg.sv
// Shared types, codes and helper functions for the rigid body Euler step block.
// Used by every module under hdl; depends on nothing else.
package rbe_pkg;

   localparam int unsigned WordW = 32;
   localparam int unsigned RegW  = 31;
   localparam int unsigned ProdW = 64;

   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_SET_CLAMP = 2'd1;
   localparam logic [1:0] OP_SET_RAW   = 2'd2;
   localparam logic [1:0] OP_NONE      = 2'd3;

   localparam logic [1:0] CSR_BODY_MASS = 2'd0;
   localparam logic [1:0] CSR_FRICTION  = 2'd1;
   localparam logic [1:0] CSR_MAX_SPEED = 2'd2;
   localparam logic [1:0] CSR_TIME_STEP = 2'd3;

   typedef enum logic [3:0] {
      LC_IDLE,
      LC_CAPTURE,
      LC_LOAD,
      LC_MUL,
      LC_DIV,
      LC_FORCE_WB,
      LC_SCALE_WB,
      LC_ZERO,
      LC_SQUARE,
      LC_MOVE_WB
   } lane_cmd_type;

   typedef struct packed {
      lane_cmd_type       cmd;
      logic               src_vel;
      logic [WordW-1:0]   mul_b;
      logic [WordW-1:0]   divisor;
   } lane_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_DSTART,
      ST_DWAIT,
      ST_WB,
      ST_SQ,
      ST_ROOT_START,
      ST_ROOT_WAIT,
      ST_DECIDE,
      ST_MOVE_MUL,
      ST_MOVE_WB,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_FORCE,
      PH_FRIC,
      PH_CLAMP
   } phase_type;

   function automatic logic [WordW-1:0] mag32(input logic signed [WordW-1:0] a);
      logic [WordW-1:0] r;
      r = a[WordW-1] ? (~a + 32'd1) : a;
      return r;
   endfunction

   // Signed, saturated view of a quotient magnitude.
   function automatic logic signed [WordW-1:0] sat_quot(input logic neg,
                                                       input logic [ProdW-1:0] q);
      logic big_pos;
      logic big_neg;
      logic [WordW-1:0] neg_q;
      logic [WordW-1:0] r;
      big_pos = (q > 64'h0000_0000_7FFF_FFFF);
      big_neg = (q > 64'h0000_0000_8000_0000);
      neg_q   = ~q[WordW-1:0] + 32'd1;
      if (neg) begin
         r = big_neg ? 32'h8000_0000 : neg_q;
      end else begin
         r = big_pos ? 32'h7FFF_FFFF : q[WordW-1:0];
      end
      return r;
   endfunction

endpackage

>>> hdl/rigid_body_euler_step.sv
// Top level of the rigid body Euler step block: sequencer, settings and lanes.
// Depends on rbe_pkg, rbe_lane and rbe_sqrt.
//
// One word at a time: a tick runs three divisions (force, friction, clamp)
// in the three lanes side by side and two square roots in the merging stage;
// fewer when friction stops the body or no clamp is needed. Set-clamped words
// run one root and at most one division, set-raw words neither. The velocity
// is held in the lanes and is zero after reset. The user must see that
// settings are written only while no word is in flight; no logic enforces it.
module rigid_body_euler_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_opcode,
   input  logic signed [rbe_pkg::WordW-1:0] req_vec_x,
   input  logic signed [rbe_pkg::WordW-1:0] req_vec_y,
   input  logic signed [rbe_pkg::WordW-1:0] req_vec_z,
   input  logic signed [rbe_pkg::WordW-1:0] req_pos_in_x,
   input  logic signed [rbe_pkg::WordW-1:0] req_pos_in_y,
   input  logic signed [rbe_pkg::WordW-1:0] req_pos_in_z,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [rbe_pkg::WordW-1:0] rsp_pos_out_x,
   output logic signed [rbe_pkg::WordW-1:0] rsp_pos_out_y,
   output logic signed [rbe_pkg::WordW-1:0] rsp_pos_out_z,
   output logic signed [rbe_pkg::WordW-1:0] rsp_vel_out_x,
   output logic signed [rbe_pkg::WordW-1:0] rsp_vel_out_y,
   output logic signed [rbe_pkg::WordW-1:0] rsp_vel_out_z,
   input  logic                             csr_wr_en,
   input  logic [1:0]                       csr_index,
   input  logic [rbe_pkg::RegW-1:0]         csr_wdata
);
   import rbe_pkg::*;

   logic [RegW-1:0] body_mass_ff, friction_ff, max_speed_ff, time_step_ff;
   logic [61:0]     fric_prod_ff;
   state_type       state_ff, state_in;
   phase_type       phase_ff, phase_in;
   logic [1:0]      op_ff, op_in;
   lane_ctrl_type   ctrl;
   logic            sqrt_start;
   logic            sqrt_done;
   logic [WordW-1:0] root;
   logic [RegW-1:0] mass_eff;
   logic [45:0]     fric_d;
   logic [2:0]      lane_done;
   logic signed [WordW-1:0] vec_arr [3];
   logic signed [WordW-1:0] pos_arr [3];
   logic signed [WordW-1:0] vel_arr [3];
   logic signed [WordW-1:0] pout_arr [3];
   logic [ProdW-1:0]        sq_arr [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         body_mass_ff <= 31'd65536;
         friction_ff  <= '0;
         max_speed_ff <= 31'd655360;
         time_step_ff <= 31'd1092;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BODY_MASS: body_mass_ff <= csr_wdata;
            CSR_FRICTION:  friction_ff  <= csr_wdata;
            CSR_MAX_SPEED: max_speed_ff <= csr_wdata;
            CSR_TIME_STEP: time_step_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      fric_prod_ff <= friction_ff * time_step_ff;
   end

   assign mass_eff = (body_mass_ff == '0) ? 31'd1 : body_mass_ff;
   assign fric_d   = fric_prod_ff[61:16];

   assign vec_arr[0] = req_vec_x;
   assign vec_arr[1] = req_vec_y;
   assign vec_arr[2] = req_vec_z;
   assign pos_arr[0] = req_pos_in_x;
   assign pos_arr[1] = req_pos_in_y;
   assign pos_arr[2] = req_pos_in_z;

   for (genvar g = 0; g < 3; g++) begin : g_lane
      rbe_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .vec      (vec_arr[g]),
         .pos_in   (pos_arr[g]),
         .vel      (vel_arr[g]),
         .pos_out  (pout_arr[g]),
         .square   (sq_arr[g]),
         .div_done (lane_done[g])
      );
   end

   rbe_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .sq    (sq_arr),
      .root  (root),
      .done  (sqrt_done)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      op_in        = op_ff;
      sqrt_start   = 1'b0;
      ctrl.cmd     = LC_IDLE;
      ctrl.src_vel = (phase_ff != PH_FORCE) || (state_ff == ST_MOVE_MUL);
      case (phase_ff)
         PH_FRIC:  ctrl.mul_b = root - fric_d[WordW-1:0];
         PH_CLAMP: ctrl.mul_b = {1'b0, max_speed_ff};
         default:  ctrl.mul_b = {1'b0, time_step_ff};
      endcase
      if (state_ff == ST_MOVE_MUL) begin
         ctrl.mul_b = {1'b0, time_step_ff};
      end
      ctrl.divisor = (phase_ff == PH_FORCE) ? {1'b0, mass_eff} : root;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.cmd = LC_CAPTURE;
               op_in    = req_opcode;
               case (req_opcode)
                  OP_TICK: begin
                     state_in = ST_MUL;
                     phase_in = PH_FORCE;
                  end
                  OP_SET_CLAMP: begin
                     state_in = ST_LOAD;
                     phase_in = PH_CLAMP;
                  end
                  OP_SET_RAW: begin
                     state_in = ST_LOAD;
                     phase_in = PH_FORCE;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_LOAD: begin
            ctrl.cmd = LC_LOAD;
            state_in = (op_ff == OP_SET_CLAMP) ? ST_SQ : ST_OUT;
         end
         ST_MUL: begin
            ctrl.cmd = LC_MUL;
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            ctrl.cmd = LC_DIV;
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (lane_done[0]) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            case (phase_ff)
               PH_FORCE: begin
                  ctrl.cmd = LC_FORCE_WB;
                  state_in = ST_SQ;
                  phase_in = PH_FRIC;
               end
               PH_FRIC: begin
                  ctrl.cmd = LC_SCALE_WB;
                  state_in = ST_SQ;
                  phase_in = PH_CLAMP;
               end
               default: begin
                  ctrl.cmd = LC_SCALE_WB;
                  state_in = (op_ff == OP_TICK) ? ST_MOVE_MUL : ST_OUT;
               end
            endcase
         end
         ST_SQ: begin
            ctrl.cmd = LC_SQUARE;
            state_in = ST_ROOT_START;
         end
         ST_ROOT_START: begin
            sqrt_start = 1'b1;
            state_in   = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (sqrt_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (phase_ff)
               PH_FRIC: begin
                  if (root == '0) begin
                     phase_in = PH_CLAMP;
                  end else if ({14'd0, root} < fric_d) begin
                     ctrl.cmd = LC_ZERO;
                     state_in = ST_MOVE_MUL;
                  end else begin
                     state_in = ST_MUL;
                  end
               end
               PH_CLAMP: begin
                  if ({1'b0, max_speed_ff} < root) begin
                     state_in = ST_MUL;
                  end else begin
                     state_in = (op_ff == OP_TICK) ? ST_MOVE_MUL : ST_OUT;
                  end
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_MOVE_MUL: begin
            ctrl.cmd = LC_MUL;
            state_in = ST_MOVE_WB;
         end
         ST_MOVE_WB: begin
            ctrl.cmd = LC_MOVE_WB;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_FORCE;
         op_ff    <= OP_TICK;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         op_ff    <= op_in;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_pos_out_x = pout_arr[0];
   assign rsp_pos_out_y = pout_arr[1];
   assign rsp_pos_out_z = pout_arr[2];
   assign rsp_vel_out_x = vel_arr[0];
   assign rsp_vel_out_y = vel_arr[1];
   assign rsp_vel_out_z = vel_arr[2];

`ifndef SYNTHESIS
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
      else $error("lane dividers out of step");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pos_out_x)
         && $stable(rsp_pos_out_y) && $stable(rsp_pos_out_z)
         && $stable(rsp_vel_out_x) && $stable(rsp_vel_out_y)
         && $stable(rsp_vel_out_z)))
      else $error("stalled result word changed");

   a_result_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result waits");

   a_root_in_range: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |=> (state_ff == ST_DECIDE))
      else $error("square root finished outside its wait state");
`endif

endmodule

>>> hdl/rbe_div.sv
// Iterative restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on rbe_pkg.
module rbe_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [rbe_pkg::ProdW-1:0] dividend,
   input  logic [rbe_pkg::WordW-1:0] divisor,
   output logic [rbe_pkg::ProdW-1:0] quotient,
   output logic                     done
);
   import rbe_pkg::*;

   logic [ProdW-1:0] num_ff, num_in;
   logic [WordW-1:0] rem_ff, rem_in;
   logic [WordW-1:0] dsr_ff, dsr_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WordW:0]   shifted;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, num_ff[ProdW-1]};
      ge      = (shifted >= {1'b0, dsr_ff});
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 6'd63;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[ProdW-2:0], ge};
         rem_in = ge ? WordW'(shifted - {1'b0, dsr_ff}) : shifted[WordW-1:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = num_ff;
   assign done     = done_ff;

endmodule

>>> hdl/rbe_lane.sv
// One vector component lane: holds its velocity and position word, multiplies,
// divides and saturates. Depends on rbe_pkg and rbe_div.
module rbe_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  rbe_pkg::lane_ctrl_type           ctrl,
   input  logic signed [rbe_pkg::WordW-1:0] vec,
   input  logic signed [rbe_pkg::WordW-1:0] pos_in,
   output logic signed [rbe_pkg::WordW-1:0] vel,
   output logic signed [rbe_pkg::WordW-1:0] pos_out,
   output logic [rbe_pkg::ProdW-1:0]        square,
   output logic                             div_done
);
   import rbe_pkg::*;

   logic signed [WordW-1:0] vec_ff, vec_in;
   logic signed [WordW-1:0] pos_ff, pos_in_w;
   logic signed [WordW-1:0] vel_ff, vel_in;
   logic [ProdW-1:0]        prod_ff, prod_in;
   logic [ProdW-1:0]        sq_ff, sq_in;
   logic                    neg_ff, neg_in;
   logic signed [WordW-1:0] src;
   logic [WordW-1:0]        vel_mag;
   logic [ProdW-1:0]        quot;
   logic signed [WordW-1:0] q_sat;
   logic [WordW:0]          force_sum;
   logic signed [WordW-1:0] force_sat;
   logic [48:0]             move_term;
   logic [48:0]             move_sum;
   logic signed [WordW-1:0] move_sat;

   rbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.cmd == LC_DIV),
      .dividend (prod_ff),
      .divisor  (ctrl.divisor),
      .quotient (quot),
      .done     (div_done)
   );

   always_comb begin
      src       = ctrl.src_vel ? vel_ff : vec_ff;
      vel_mag   = mag32(vel_ff);
      q_sat     = sat_quot(neg_ff, quot);
      force_sum = {vel_ff[WordW-1], vel_ff} + {q_sat[WordW-1], q_sat};
      if (force_sum[WordW] == force_sum[WordW-1]) begin
         force_sat = force_sum[WordW-1:0];
      end else begin
         force_sat = force_sum[WordW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      move_term = {2'b00, prod_ff[62:16]};
      if (neg_ff) begin
         move_term = ~move_term + 49'd1;
      end
      move_sum = {{17{pos_ff[WordW-1]}}, pos_ff} + move_term;
      if (move_sum[48:31] == {18{move_sum[31]}}) begin
         move_sat = move_sum[WordW-1:0];
      end else begin
         move_sat = move_sum[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end

      vec_in   = vec_ff;
      pos_in_w = pos_ff;
      vel_in   = vel_ff;
      prod_in  = prod_ff;
      sq_in    = sq_ff;
      neg_in   = neg_ff;
      case (ctrl.cmd)
         LC_CAPTURE: begin
            vec_in   = vec;
            pos_in_w = pos_in;
         end
         LC_LOAD:     vel_in = vec_ff;
         LC_MUL: begin
            prod_in = mag32(src) * ctrl.mul_b;
            neg_in  = src[WordW-1];
         end
         LC_FORCE_WB: vel_in = force_sat;
         LC_SCALE_WB: vel_in = q_sat;
         LC_ZERO:     vel_in = '0;
         LC_SQUARE:   sq_in = vel_mag * vel_mag;
         LC_MOVE_WB:  pos_in_w = move_sat;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff <= '0;
      end else begin
         vel_ff <= vel_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff  <= vec_in;
      pos_ff  <= pos_in_w;
      prod_ff <= prod_in;
      sq_ff   <= sq_in;
      neg_ff  <= neg_in;
   end

   assign vel     = vel_ff;
   assign pos_out = pos_ff;
   assign square  = sq_ff;

endmodule

>>> hdl/rbe_sqrt.sv
// Merging stage: sums the three lane squares and takes the integer square root
// two bits per cycle. Depends on rbe_pkg.
module rbe_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rbe_pkg::ProdW-1:0] sq [3],
   output logic [rbe_pkg::WordW-1:0] root,
   output logic                      done
);
   import rbe_pkg::*;

   logic [ProdW-1:0] n_ff, n_in;
   logic [ProdW-1:0] res_ff, res_in;
   logic [ProdW-1:0] bit_ff, bit_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [ProdW-1:0] trial;
   logic             ge;

   always_comb begin
      trial   = res_ff + bit_ff;
      ge      = (n_ff >= trial);
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = sq[0] + sq[1] + sq[2];
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         cnt_in  = 5'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in   = ge ? (n_ff - trial) : n_ff;
         res_in = ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign root = res_ff[WordW-1:0];
   assign done = done_ff;

endmodule

>>> test/rbe_checker.sv
// Checker for the rigid body Euler step block: follows the request and response
// channels, predicts each response word and compares it. Depends on rbe_pkg.
module rbe_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [1:0]                       req_opcode,
   input  logic signed [rbe_pkg::WordW-1:0] req_vec_x,
   input  logic signed [rbe_pkg::WordW-1:0] req_vec_y,
   input  logic signed [rbe_pkg::WordW-1:0] req_vec_z,
   input  logic signed [rbe_pkg::WordW-1:0] req_pos_in_x,
   input  logic signed [rbe_pkg::WordW-1:0] req_pos_in_y,
   input  logic signed [rbe_pkg::WordW-1:0] req_pos_in_z,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [rbe_pkg::WordW-1:0] rsp_pos_out_x,
   input  logic signed [rbe_pkg::WordW-1:0] rsp_pos_out_y,
   input  logic signed [rbe_pkg::WordW-1:0] rsp_pos_out_z,
   input  logic signed [rbe_pkg::WordW-1:0] rsp_vel_out_x,
   input  logic signed [rbe_pkg::WordW-1:0] rsp_vel_out_y,
   input  logic signed [rbe_pkg::WordW-1:0] rsp_vel_out_z,
   input  logic                             csr_wr_en,
   input  logic [1:0]                       csr_index,
   input  logic [rbe_pkg::RegW-1:0]         csr_wdata,
   output int                               fail_count,
   output int                               pending
);
   import rbe_pkg::*;

   typedef struct {
      logic signed [31:0] pos [3];
      logic signed [31:0] vel [3];
   } body_state_type;

   logic [30:0] mass_reg, fric_reg, vmax_reg, dt_reg;
   longint vel_q [3];
   body_state_type motion_q [$];
   int err_shown;

   function automatic longint sat_word(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint scale_trunc(input longint a, input longint unsigned b,
                                          input longint unsigned c);
      longint unsigned m;
      m = ((a < 0) ? longint'(-a) : a) * b / c;
      if (m > 64'h7FFF_FFFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF_FFFF;
      return (a < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned speed_of(input longint v [3]);
      longint unsigned n, res, bit_v, m;
      n = 0;
      for (int i = 0; i < 3; i++) begin
         m = (v[i] < 0) ? longint'(-v[i]) : v[i];
         n += m * m;
      end
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   task automatic limit_speed(inout longint v [3]);
      longint unsigned s;
      s = speed_of(v);
      if (vmax_reg < s)
         for (int i = 0; i < 3; i++) v[i] = scale_trunc(v[i], vmax_reg, s);
   endtask

   task automatic predict_motion(input logic [1:0] op, input longint f [3],
                                 input longint p [3]);
      longint unsigned mass, d, s;
      longint v [3];
      body_state_type r;
      v = f;
      if (op == OP_TICK) begin
         mass = (mass_reg == 0) ? 1 : mass_reg;
         for (int i = 0; i < 3; i++)
            vel_q[i] = sat_word(vel_q[i] + sat_word(scale_trunc(f[i], dt_reg, mass)));
         d = (longint'(fric_reg) * dt_reg) >> 16;
         s = speed_of(vel_q);
         if (s != 0) begin
            for (int i = 0; i < 3; i++)
               vel_q[i] = (s < d) ? 0 : scale_trunc(vel_q[i], s - d, s);
         end
         limit_speed(vel_q);
         for (int i = 0; i < 3; i++)
            p[i] = sat_word(p[i] + scale_trunc(vel_q[i], dt_reg, 65536));
      end else if (op == OP_SET_CLAMP) begin
         limit_speed(v);
         vel_q = v;
      end else if (op == OP_SET_RAW) begin
         vel_q = v;
      end
      for (int i = 0; i < 3; i++) begin
         r.pos[i] = p[i][31:0];
         r.vel[i] = vel_q[i][31:0];
      end
      motion_q.push_back(r);
   endtask

   assign pending = motion_q.size();

   always @(posedge clock) begin
      longint f [3], p [3];
      body_state_type e;
      logic signed [31:0] got [6];
      logic signed [31:0] want [6];
      if (reset) begin
         mass_reg <= 31'd65536;
         fric_reg <= 31'd0;
         vmax_reg <= 31'd655360;
         dt_reg <= 31'd1092;
         vel_q = '{0, 0, 0};
         motion_q.delete();
         fail_count <= 0;
         err_shown = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BODY_MASS: mass_reg <= csr_wdata;
               CSR_FRICTION: fric_reg <= csr_wdata;
               CSR_MAX_SPEED: vmax_reg <= csr_wdata;
               CSR_TIME_STEP: dt_reg <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_pos_out_x, rsp_pos_out_y, rsp_pos_out_z,
                    rsp_vel_out_x, rsp_vel_out_y, rsp_vel_out_z};
            if (motion_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (err_shown < 10) $display("Unexpected response word at %0t", $time);
               err_shown++;
            end else begin
               e = motion_q.pop_front();
               want = '{e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1], e.vel[2]};
               if (got != want) begin
                  fail_count <= fail_count + 1;
                  if (err_shown < 10)
                     $display({"Mismatch at %0t: expected pos %0d %0d %0d ",
                               "vel %0d %0d %0d, got pos %0d %0d %0d vel %0d %0d %0d"},
                              $time, want[0], want[1], want[2], want[3], want[4], want[5],
                              got[0], got[1], got[2], got[3], got[4], got[5]);
                  err_shown++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            f = '{req_vec_x, req_vec_y, req_vec_z};
            p = '{req_pos_in_x, req_pos_in_y, req_pos_in_z};
            predict_motion(req_opcode, f, p);
         end
      end
   end
endmodule

>>> test/testbench.sv
// Top of the rigid body Euler step test: clock, reset, settings, request stimulus
// with random idling, and the verdict. Depends on rbe_pkg, rbe_checker and the block.
module testbench;
   import rbe_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic [1:0] req_opcode;
   logic signed [31:0] req_vec_x, req_vec_y, req_vec_z;
   logic signed [31:0] req_pos_in_x, req_pos_in_y, req_pos_in_z;
   logic signed [31:0] rsp_pos_out_x, rsp_pos_out_y, rsp_pos_out_z;
   logic signed [31:0] rsp_vel_out_x, rsp_vel_out_y, rsp_vel_out_z;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [30:0] csr_wdata;
   int fail_count, pending, req_idle_pct, rsp_idle_pct, quiet_cycles;

   rigid_body_euler_step dut (.*);
   rbe_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 0;
         3: return $urandom;
         default: return $signed($urandom_range(2000000)) - 1000000;
      endcase
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic send_word(input logic [1:0] op, input logic signed [31:0] vx,
                            input logic signed [31:0] vy, input logic signed [31:0] vz,
                            input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] pz);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_vec_x <= vx;
      req_vec_y <= vy;
      req_vec_z <= vz;
      req_pos_in_x <= px;
      req_pos_in_y <= py;
      req_pos_in_z <= pz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      logic [1:0] op;
      for (int n = 0; n < count; n++) begin
         op = $urandom_range(9) < 6 ? OP_TICK : 2'($urandom_range(3));
         send_word(op, pick_word(), pick_word(), pick_word(),
                   pick_word(), pick_word(), pick_word());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_TICK;
      {req_vec_x, req_vec_y, req_vec_z} = '0;
      {req_pos_in_x, req_pos_in_y, req_pos_in_z} = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_BODY_MASS;
      csr_wdata = '0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(OP_TICK, 32'sh0001_0000, 0, 0, 0, 0, 0);
      send_word(OP_TICK, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 5);
      send_word(OP_SET_CLAMP, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 2, 3);
      send_word(OP_SET_CLAMP, 0, 0, 0, 0, 0, 0);
      send_word(OP_SET_RAW, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0);
      send_word(OP_TICK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_word(OP_NONE, -1, -1, -1, 32'sh8000_0000, -1, 0);
      send_word(OP_SET_RAW, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 0, 0);
      send_word(OP_TICK, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      drain();

      write_reg(CSR_BODY_MASS, 31'd0);
      write_reg(CSR_FRICTION, 31'h7FFF_FFFF);
      write_reg(CSR_MAX_SPEED, 31'h7FFF_FFFF);
      write_reg(CSR_TIME_STEP, 31'h7FFF_FFFF);
      send_word(OP_SET_RAW, 32'sh0010_0000, 0, 0, 0, 0, 0);
      send_word(OP_TICK, 0, 0, 0, 0, 0, 0);
      send_word(OP_TICK, 32'sh7FFF_FFFF, -5, 9, 0, 0, 0);
      drain();

      write_reg(CSR_BODY_MASS, 31'h7FFF_FFFF);
      write_reg(CSR_FRICTION, 31'd0);
      write_reg(CSR_MAX_SPEED, 31'd0);
      write_reg(CSR_TIME_STEP, 31'd0);
      send_word(OP_SET_CLAMP, 32'sh0001_0000, 3, -3, 0, 0, 0);
      send_word(OP_TICK, 32'sh7FFF_FFFF, 0, 0, 7, 7, 7);
      drain();

      req_idle_pct = 16;
      rsp_idle_pct = 80;
      write_reg(CSR_BODY_MASS, 31'd65536);
      write_reg(CSR_FRICTION, 31'd32768);
      write_reg(CSR_MAX_SPEED, 31'd655360);
      write_reg(CSR_TIME_STEP, 31'd1092);
      send_random(270);
      drain();

      req_idle_pct = 80;
      rsp_idle_pct = 16;
      write_reg(CSR_BODY_MASS, 31'($urandom_range(32'h7FFF_FFFF)));
      write_reg(CSR_FRICTION, 31'($urandom_range(32'h0010_0000)));
      write_reg(CSR_MAX_SPEED, 31'($urandom));
      write_reg(CSR_TIME_STEP, 31'($urandom_range(32'h0001_0000)));
      send_random(270);
      drain();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_reg(CSR_BODY_MASS, 31'd1);
      write_reg(CSR_FRICTION, 31'd655360);
      write_reg(CSR_MAX_SPEED, 31'h7FFF_FFFF);
      write_reg(CSR_TIME_STEP, 31'd65536);
      send_random(260);
      drain();

      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
